@@ rtl/pfpv_pkg.sv @@
// Package for the PIC/FLIP particle velocity block.
// Holds opcodes, register indexes, the pipeline sideband type and the fixed-point helpers.
// No dependencies.
`default_nettype none

package pfpv_pkg;

  // Item opcodes
  localparam logic [2:0] OP_WR_U        = 3'd0;
  localparam logic [2:0] OP_WR_V        = 3'd1;
  localparam logic [2:0] OP_WR_SAVED_U  = 3'd2;
  localparam logic [2:0] OP_WR_SAVED_V  = 3'd3;
  localparam logic [2:0] OP_PARTICLE    = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_CELL_SIZE   = 3'd2;
  localparam logic [2:0] CFG_INV_CELL    = 3'd3;
  localparam logic [2:0] CFG_PIC_WEIGHT  = 3'd4;
  localparam logic [2:0] CFG_UNKNOWN_VEL = 3'd5;

  // Steps of the position divider, one quotient bit each
  localparam int DIV_W = 32;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // Item fields that ride along the pipeline
  typedef struct packed {
    logic [2:0]         opcode;
    logic [6:0]         col;
    logic [6:0]         row;
    logic signed [31:0] grid_value;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               neg_x;
    logic               neg_y;
  } sb_t;

  // Unrounded linear interpolation a*(1-w) + b*w, with 16 extra fraction bits (Q.16 scaled)
  function automatic logic signed [51:0] lerp_sum(input logic signed [32:0] a,
                                                  input logic signed [32:0] b,
                                                  input logic [16:0]        w);
    logic signed [17:0] wa;
    logic signed [17:0] wb;
    logic signed [51:0] pa;
    logic signed [51:0] pb;
    wa = $signed({1'b0, 17'(ONE_Q16 - w)});
    wb = $signed({1'b0, w});
    pa = a * wa;
    pb = b * wb;
    return pa + pb;
  endfunction

  // Round half up and drop 16 fraction bits
  function automatic logic signed [33:0] round_lerp(input logic signed [51:0] s);
    logic signed [51:0] t;
    t = s + 52'sd32768;
    return 34'(t >>> 16);
  endfunction

  // Unrounded blend alpha*pic + (1-alpha)*(old+flip)
  function automatic logic signed [53:0] blend_sum(input logic signed [33:0] pic,
                                                   input logic signed [34:0] old_flip,
                                                   input logic [16:0]        alpha);
    logic signed [17:0] wa;
    logic signed [17:0] wb;
    logic signed [53:0] pa;
    logic signed [53:0] pb;
    wa = $signed({1'b0, alpha});
    wb = $signed({1'b0, 17'(ONE_Q16 - alpha)});
    pa = pic * wa;
    pb = old_flip * wb;
    return pa + pb;
  endfunction

  // Round half up, drop 16 fraction bits and saturate to 32 bits
  function automatic logic signed [31:0] round_sat(input logic signed [53:0] s);
    logic signed [53:0] t;
    logic signed [37:0] r;
    t = s + 54'sd32768;
    r = 38'(t >>> 16);
    if (r[37:31] == 7'h00 || r[37:31] == 7'h7F) begin
      return r[31:0];
    end else if (r[37]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

`default_nettype wire

@@ rtl/pfpv_ram.sv @@
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none

module pfpv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4160
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered reads, held while disabled
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata0_o <= mem_q[raddr0_i];
      rdata1_o <= mem_q[raddr1_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/pfpv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on pfpv_pkg.
`default_nettype none

module pfpv_div (
  input  wire logic                        clk_i,
  input  wire logic                        en_i,
  input  wire logic [pfpv_pkg::DIV_W-1:0]  dividend_i,
  input  wire logic [30:0]                 divisor_i,
  output logic      [pfpv_pkg::DIV_W-1:0]  quo_o,
  output logic      [30:0]                 rem_o
);
  import pfpv_pkg::*;

  logic [DIV_W-1:0] num_q [DIV_W];
  logic [DIV_W-1:0] num_d [DIV_W];
  logic [30:0]      rem_q [DIV_W];
  logic [30:0]      rem_d [DIV_W];

  // One trial subtraction per stage
  always_comb begin
    logic [DIV_W-1:0] num_in;
    logic [30:0]      rem_in;
    logic [31:0]      shifted;
    logic             ge;
    for (int k = 0; k < DIV_W; k++) begin
      num_in  = (k == 0) ? dividend_i : num_q[(k == 0) ? 0 : k - 1];
      rem_in  = (k == 0) ? 31'd0 : rem_q[(k == 0) ? 0 : k - 1];
      shifted = {rem_in, num_in[DIV_W-1]};
      ge      = shifted >= {1'b0, divisor_i};
      rem_d[k] = ge ? 31'(shifted - {1'b0, divisor_i}) : shifted[30:0];
      num_d[k] = {num_in[DIV_W-2:0], ge};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign quo_o = num_q[DIV_W-1];
  assign rem_o = rem_q[DIV_W-1];

endmodule

`default_nettype wire

@@ rtl/pic_flip_particle_velocity_top.sv @@
// PIC/FLIP grid-to-particle velocity transfer: staggered u/v grids with saved copies,
// written by grid items and read by particle items. Depends on pfpv_pkg, pfpv_div, pfpv_ram.
//
// One item enters per cycle when the output side keeps up. A particle's cell is found
// from its position by the 32-step pipelined divider; then the floor fix, weight
// multiply, grid read, interpolation and blend stages follow. Grid writes travel the
// same pipeline, so every particle sees exactly the writes transferred before it. The
// grid memories need no clearing pass: unwritten entries hold no defined value.
`default_nettype none

module pic_flip_particle_velocity_top #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration writes
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [6:0]  col_i,
  input  wire logic [6:0]  row_i,
  input  wire logic [31:0] grid_value_i,
  input  wire logic [31:0] pos_x_i,
  input  wire logic [31:0] pos_y_i,
  input  wire logic [31:0] vel_x_i,
  input  wire logic [31:0] vel_y_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      new_vel_x_o,
  output logic [31:0]      new_vel_y_o,
  output logic             inside_grid_o
);
  import pfpv_pkg::*;

  localparam int UD  = (MAX_WIDTH + 1) * MAX_HEIGHT;
  localparam int VD  = MAX_WIDTH * (MAX_HEIGHT + 1);
  localparam int UAW = $clog2(UD);
  localparam int VAW = $clog2(VD);
  localparam int XW  = $clog2(MAX_WIDTH + 1);
  localparam int YW  = $clog2(MAX_HEIGHT + 1);
  localparam int AWW = 8 + $clog2(MAX_HEIGHT + 2);

  // ---------------- configuration registers ----------------
  logic [6:0]         grid_width_q, grid_height_q;
  logic [30:0]        cell_size_q, inv_cell_q;
  logic [16:0]        pic_weight_q;
  logic signed [31:0] unknown_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= 7'd64;
      grid_height_q <= 7'd64;
      cell_size_q   <= 31'd65536;
      inv_cell_q    <= 31'd65536;
      pic_weight_q  <= 17'd65536;
      unknown_vel_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[6:0];
        CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i[6:0];
        CFG_CELL_SIZE:   cell_size_q   <= cfg_data_i[30:0];
        CFG_INV_CELL:    inv_cell_q    <= cfg_data_i[30:0];
        CFG_PIC_WEIGHT:  pic_weight_q  <= cfg_data_i[16:0];
        CFG_UNKNOWN_VEL: unknown_vel_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [30:0]   divisor;
  logic [XW-1:0] gw;
  logic [YW-1:0] gh;
  logic [16:0]   alpha;

  assign divisor = (cell_size_q == 31'd0) ? 31'd1 : cell_size_q;
  assign gw      = (grid_width_q > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(grid_width_q);
  assign gh      = (grid_height_q > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(grid_height_q);
  assign alpha   = (pic_weight_q > ONE_Q16) ? ONE_Q16 : pic_weight_q;

  // ---------------- pipeline control ----------------
  logic en;
  logic vld_b_q, part_b_q, out_valid_q;

  // Advance unless a finished particle waits on a full output register
  assign en         = !(vld_b_q && part_b_q) || !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // ---------------- divider stages ----------------
  logic [31:0] mag_x, mag_y;
  logic [31:0] quo_x, quo_y;
  logic [30:0] rem_x, rem_y;

  assign mag_x = pos_x_i[31] ? 32'(~pos_x_i + 32'd1) : pos_x_i;
  assign mag_y = pos_y_i[31] ? 32'(~pos_y_i + 32'd1) : pos_y_i;

  pfpv_div u_div_x (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (mag_x),
    .divisor_i  (divisor),
    .quo_o      (quo_x),
    .rem_o      (rem_x)
  );

  pfpv_div u_div_y (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (mag_y),
    .divisor_i  (divisor),
    .quo_o      (quo_y),
    .rem_o      (rem_y)
  );

  sb_t  sb_in;
  sb_t  sb_q  [DIV_W];
  logic vld_q [DIV_W];

  always_comb begin
    sb_in.opcode     = opcode_i;
    sb_in.col        = col_i;
    sb_in.row        = row_i;
    sb_in.grid_value = grid_value_i;
    sb_in.vel_x      = vel_x_i;
    sb_in.vel_y      = vel_y_i;
    sb_in.neg_x      = pos_x_i[31];
    sb_in.neg_y      = pos_y_i[31];
  end

  // Carry valid bits alongside the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DIV_W; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < DIV_W; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_q[0] <= sb_in;
      for (int k = 1; k < DIV_W; k++) sb_q[k] <= sb_q[k-1];
    end
  end

  // ---------------- F: floor correction and grid bounds ----------------
  sb_t           sb_f_q;
  logic          vld_f_q, inside_f_q;
  logic [XW-1:0] i_f_q;
  logic [YW-1:0] j_f_q;
  logic [30:0]   rx_f_q, ry_f_q;
  logic          adj_x, adj_y, inside_d;

  assign adj_x    = sb_q[DIV_W-1].neg_x && (quo_x != '0 || rem_x != '0);
  assign adj_y    = sb_q[DIV_W-1].neg_y && (quo_y != '0 || rem_y != '0);
  assign inside_d = !adj_x && !adj_y && (quo_x < 32'(gw)) && (quo_y < 32'(gh));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_f_q     <= sb_q[DIV_W-1];
      inside_f_q <= inside_d;
      i_f_q      <= quo_x[XW-1:0];
      j_f_q      <= quo_y[YW-1:0];
      rx_f_q     <= (sb_q[DIV_W-1].neg_x && rem_x != '0) ? 31'(divisor - rem_x) : rem_x;
      ry_f_q     <= (sb_q[DIV_W-1].neg_y && rem_y != '0) ? 31'(divisor - rem_y) : rem_y;
    end
  end

  // ---------------- M: weight product and grid addresses ----------------
  sb_t            sb_m_q;
  logic           vld_m_q, inside_m_q;
  logic [61:0]    prod_x_m_q, prod_y_m_q;
  logic [UAW-1:0] ua0_m_q, ua1_m_q;
  logic [VAW-1:0] va0_m_q, va1_m_q;
  logic [AWW-1:0] ua_wide, va_wide;
  logic           part_f;

  assign part_f = (sb_f_q.opcode == OP_PARTICLE);

  always_comb begin
    if (part_f) begin
      ua_wide = AWW'(i_f_q) * AWW'(MAX_HEIGHT) + AWW'(j_f_q);
      va_wide = AWW'(i_f_q) * AWW'(MAX_HEIGHT + 1) + AWW'(j_f_q);
    end else begin
      ua_wide = AWW'(sb_f_q.col) * AWW'(MAX_HEIGHT) + AWW'(sb_f_q.row);
      va_wide = AWW'(sb_f_q.col) * AWW'(MAX_HEIGHT + 1) + AWW'(sb_f_q.row);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_m_q     <= sb_f_q;
      inside_m_q <= inside_f_q;
      prod_x_m_q <= 62'(rx_f_q) * 62'(inv_cell_q);
      prod_y_m_q <= 62'(ry_f_q) * 62'(inv_cell_q);
      ua0_m_q    <= UAW'(ua_wide);
      ua1_m_q    <= UAW'(ua_wide + AWW'(MAX_HEIGHT));
      va0_m_q    <= VAW'(va_wide);
      va1_m_q    <= VAW'(va_wide + AWW'(1));
    end
  end

  // ---------------- R: grid memories and weight rounding ----------------
  logic ok_u, ok_v;
  logic we_u, we_us, we_v, we_vs;
  logic [31:0] u0, u1, us0, us1, v0, v1, vs0, vs1;

  assign ok_u  = (sb_m_q.col <= MAX_WIDTH) && (sb_m_q.row < MAX_HEIGHT);
  assign ok_v  = (sb_m_q.col < MAX_WIDTH) && (sb_m_q.row <= MAX_HEIGHT);
  assign we_u  = en && vld_m_q && ok_u && (sb_m_q.opcode == OP_WR_U);
  assign we_us = en && vld_m_q && ok_u && (sb_m_q.opcode == OP_WR_SAVED_U);
  assign we_v  = en && vld_m_q && ok_v && (sb_m_q.opcode == OP_WR_V);
  assign we_vs = en && vld_m_q && ok_v && (sb_m_q.opcode == OP_WR_SAVED_V);

  pfpv_ram #(.WIDTH(32), .DEPTH(UD)) u_ram_u (
    .clk_i (clk_i), .en_i (en), .we_i (we_u), .waddr_i (ua0_m_q),
    .wdata_i (sb_m_q.grid_value), .raddr0_i (ua0_m_q), .raddr1_i (ua1_m_q),
    .rdata0_o (u0), .rdata1_o (u1)
  );

  pfpv_ram #(.WIDTH(32), .DEPTH(UD)) u_ram_us (
    .clk_i (clk_i), .en_i (en), .we_i (we_us), .waddr_i (ua0_m_q),
    .wdata_i (sb_m_q.grid_value), .raddr0_i (ua0_m_q), .raddr1_i (ua1_m_q),
    .rdata0_o (us0), .rdata1_o (us1)
  );

  pfpv_ram #(.WIDTH(32), .DEPTH(VD)) u_ram_v (
    .clk_i (clk_i), .en_i (en), .we_i (we_v), .waddr_i (va0_m_q),
    .wdata_i (sb_m_q.grid_value), .raddr0_i (va0_m_q), .raddr1_i (va1_m_q),
    .rdata0_o (v0), .rdata1_o (v1)
  );

  pfpv_ram #(.WIDTH(32), .DEPTH(VD)) u_ram_vs (
    .clk_i (clk_i), .en_i (en), .we_i (we_vs), .waddr_i (va0_m_q),
    .wdata_i (sb_m_q.grid_value), .raddr0_i (va0_m_q), .raddr1_i (va1_m_q),
    .rdata0_o (vs0), .rdata1_o (vs1)
  );

  sb_t         sb_r_q;
  logic        vld_r_q, inside_r_q;
  logic [16:0] wx_r_q, wy_r_q;
  logic [46:0] wx_rnd, wy_rnd;

  assign wx_rnd = 47'((prod_x_m_q + 62'd32768) >> 16);
  assign wy_rnd = 47'((prod_y_m_q + 62'd32768) >> 16);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_r_q     <= sb_m_q;
      inside_r_q <= inside_m_q;
      wx_r_q     <= (wx_rnd > 47'(ONE_Q16)) ? ONE_Q16 : wx_rnd[16:0];
      wy_r_q     <= (wy_rnd > 47'(ONE_Q16)) ? ONE_Q16 : wy_rnd[16:0];
    end
  end

  // ---------------- L: interpolation products ----------------
  sb_t                sb_l_q;
  logic               vld_l_q, inside_l_q;
  logic signed [51:0] pic_u_l_q, flip_u_l_q, pic_v_l_q, flip_v_l_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sb_l_q     <= sb_r_q;
      inside_l_q <= inside_r_q;
      pic_u_l_q  <= lerp_sum(33'($signed(u0)), 33'($signed(u1)), wx_r_q);
      pic_v_l_q  <= lerp_sum(33'($signed(v0)), 33'($signed(v1)), wy_r_q);
      flip_u_l_q <= lerp_sum(33'($signed(u0)) - 33'($signed(us0)),
                             33'($signed(u1)) - 33'($signed(us1)), wx_r_q);
      flip_v_l_q <= lerp_sum(33'($signed(v0)) - 33'($signed(vs0)),
                             33'($signed(v1)) - 33'($signed(vs1)), wy_r_q);
    end
  end

  // ---------------- B: round interpolants and blend ----------------
  logic               inside_b_q;
  logic signed [53:0] bx_b_q, by_b_q;
  logic signed [33:0] pic_u, flip_u, pic_v, flip_v;

  always_comb begin
    if (inside_l_q) begin
      pic_u  = round_lerp(pic_u_l_q);
      flip_u = round_lerp(flip_u_l_q);
      pic_v  = round_lerp(pic_v_l_q);
      flip_v = round_lerp(flip_v_l_q);
    end else begin
      pic_u  = 34'(unknown_vel_q);
      flip_u = 34'(unknown_vel_q);
      pic_v  = 34'(unknown_vel_q);
      flip_v = 34'(unknown_vel_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inside_b_q <= inside_l_q;
      part_b_q   <= (sb_l_q.opcode == OP_PARTICLE);
      bx_b_q     <= blend_sum(pic_u, 35'(sb_l_q.vel_x) + 35'(flip_u), alpha);
      by_b_q     <= blend_sum(pic_v, 35'(sb_l_q.vel_y) + 35'(flip_v), alpha);
    end
  end

  // Valid bits of the stages after the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
      vld_m_q <= 1'b0;
      vld_r_q <= 1'b0;
      vld_l_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en) begin
      vld_f_q <= vld_q[DIV_W-1];
      vld_m_q <= vld_f_q;
      vld_r_q <= vld_m_q;
      vld_l_q <= vld_r_q;
      vld_b_q <= vld_l_q;
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en && vld_b_q && part_b_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_b_q && part_b_q) begin
      new_vel_x_o   <= round_sat(bx_b_q);
      new_vel_y_o   <= round_sat(by_b_q);
      inside_grid_o <= inside_b_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  // A finished particle blocked by a full output must stall the input
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && part_b_q && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while pipeline is blocked");

  // A finished particle that advances shows up as a result
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_b_q && part_b_q && en) |=> out_valid_o)
    else $error("particle result lost");

  // No grid write while the pipeline is held
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> !(we_u || we_us || we_v || we_vs))
    else $error("grid written during stall");
`endif

endmodule

`default_nettype wire

@@ test/pic_flip_particle_velocity_top_tb.sv @@
// Testbench for pic_flip_particle_velocity_top: drives grid writes and particles under
// random backpressure and checks every velocity against an in-bench PIC/FLIP predictor.
// Depends on pfpv_pkg and the block's RTL.
`timescale 1ns / 100ps

module pic_flip_particle_velocity_top_tb;
  import pfpv_pkg::*;

  localparam int GRID_W    = 64;
  localparam int GRID_H    = 64;
  localparam int U_DEPTH   = (GRID_W + 1) * GRID_H;
  localparam int V_DEPTH   = GRID_W * (GRID_H + 1);
  localparam int SETTLE    = DIV_W + 13;
  localparam logic [2:0] OP_UNUSED_MIN = 3'd5;
  localparam logic [2:0] OP_UNUSED_MID = 3'd6;
  localparam logic [2:0] OP_UNUSED_MAX = 3'd7;

  typedef struct {
    logic [2:0]  op;
    logic [6:0]  col;
    logic [6:0]  row;
    logic [31:0] gval;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] vx;
    logic [31:0] vy;
  } grid_item_t;

  typedef struct {
    logic [31:0] vx;
    logic [31:0] vy;
    logic        in_grid;
  } velocity_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  opcode_i = '0;
  logic [6:0]  col_i = '0;
  logic [6:0]  row_i = '0;
  logic [31:0] grid_value_i = '0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] vel_x_i = '0;
  logic [31:0] vel_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] new_vel_x_o;
  logic [31:0] new_vel_y_o;
  logic        inside_grid_o;

  pic_flip_particle_velocity_top DUT (.*);

  // Predictor state: configuration, grids and which entries hold a value
  logic [6:0]          cfg_gw, cfg_gh;
  logic [30:0]         cfg_cs, cfg_inv;
  logic [16:0]         cfg_alpha;
  logic signed [31:0]  cfg_unknown;
  logic signed [31:0]  u_grid[U_DEPTH], u_saved[U_DEPTH];
  logic signed [31:0]  v_grid[V_DEPTH], v_saved[V_DEPTH];
  bit                  u_set[U_DEPTH], us_set[U_DEPTH];
  bit                  v_set[V_DEPTH], vs_set[V_DEPTH];

  grid_item_t item_backlog[$];
  velocity_t  velocity_due[$];

  int errors = 0;
  int results_seen = 0;
  int particles_sent = 0;
  int inside_sent = 0;
  int writes_sent = 0;
  int items_queued = 0;
  int phases_run = 0;
  int cyc = 0;
  int burst_left = 4;
  int gap_left = 0;
  int stall_left = 0;

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  // Cell index along one axis and the Q1.16 weight within it
  function automatic longint locate_cell(input logic [31:0] p, output longint w);
    longint d, q, r, prod;
    d = (cfg_cs == 0) ? 1 : longint'(cfg_cs);
    q = longint'($signed(p)) / d;
    r = longint'($signed(p)) - q * d;
    if (r < 0) begin
      q = q - 1;
      r = r + d;
    end
    prod = (r * longint'(cfg_inv) + 32768) >>> 16;
    w = (prod > 65536) ? 65536 : prod;
    return q;
  endfunction

  function automatic longint round_half_up(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint lerp_q16(input longint a, input longint b, input longint w);
    return round_half_up(a * (65536 - w) + b * w);
  endfunction

  function automatic logic [31:0] blend_velocity(input longint pic, input longint flip,
                                                 input logic [31:0] old);
    longint alpha, r;
    alpha = (cfg_alpha > 65536) ? 65536 : longint'(cfg_alpha);
    r = round_half_up(alpha * pic + (65536 - alpha) * (longint'($signed(old)) + flip));
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic int eff_width();
    return (cfg_gw > GRID_W) ? GRID_W : int'(cfg_gw);
  endfunction

  function automatic int eff_height();
    return (cfg_gh > GRID_H) ? GRID_H : int'(cfg_gh);
  endfunction

  // Update the grids or work out the blended velocity for one item
  task automatic track_grid_item(input grid_item_t it);
    int ia, ib;
    longint ci, cj, wx, wy, pu, pv, fu, fv;
    velocity_t res;
    case (it.op)
      OP_WR_U, OP_WR_SAVED_U: begin
        if (it.col <= GRID_W && it.row < GRID_H) begin
          ia = it.col * GRID_H + it.row;
          if (it.op == OP_WR_U) begin
            u_grid[ia] = it.gval;
            u_set[ia] = 1'b1;
          end else begin
            u_saved[ia] = it.gval;
            us_set[ia] = 1'b1;
          end
        end
        writes_sent++;
      end
      OP_WR_V, OP_WR_SAVED_V: begin
        if (it.col < GRID_W && it.row <= GRID_H) begin
          ia = it.col * (GRID_H + 1) + it.row;
          if (it.op == OP_WR_V) begin
            v_grid[ia] = it.gval;
            v_set[ia] = 1'b1;
          end else begin
            v_saved[ia] = it.gval;
            vs_set[ia] = 1'b1;
          end
        end
        writes_sent++;
      end
      OP_PARTICLE: begin
        ci = locate_cell(it.px, wx);
        cj = locate_cell(it.py, wy);
        res.in_grid = (ci >= 0 && ci < eff_width() && cj >= 0 && cj < eff_height());
        if (res.in_grid) begin
          ia = int'(ci) * GRID_H + int'(cj);
          ib = int'(ci) * (GRID_H + 1) + int'(cj);
          pu = lerp_q16(u_grid[ia], u_grid[ia + GRID_H], wx);
          pv = lerp_q16(v_grid[ib], v_grid[ib + 1], wy);
          fu = lerp_q16(longint'(u_grid[ia]) - u_saved[ia],
                        longint'(u_grid[ia + GRID_H]) - u_saved[ia + GRID_H], wx);
          fv = lerp_q16(longint'(v_grid[ib]) - v_saved[ib],
                        longint'(v_grid[ib + 1]) - v_saved[ib + 1], wy);
          inside_sent++;
        end else begin
          pu = cfg_unknown;
          pv = cfg_unknown;
          fu = cfg_unknown;
          fv = cfg_unknown;
        end
        res.vx = blend_velocity(pu, fu, it.vx);
        res.vy = blend_velocity(pv, fv, it.vy);
        velocity_due = {velocity_due, res};
        particles_sent++;
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(input grid_item_t it);
    track_grid_item(it);
    item_backlog = {item_backlog, it};
    items_queued++;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000);
    endcase
  endfunction

  task automatic queue_write(input logic [2:0] op, input int col, input int row,
                             input logic [31:0] val);
    grid_item_t it;
    it = '{op: op, col: col[6:0], row: row[6:0], gval: val,
           px: $urandom, py: $urandom, vx: $urandom, vy: $urandom};
    queue_item(it);
  endtask

  // Load any entry the particle would read that holds no value yet, then send it
  task automatic queue_particle(input logic [31:0] px, input logic [31:0] py,
                                input logic [31:0] vx, input logic [31:0] vy);
    longint ci, cj, w;
    int ia, ib;
    grid_item_t it;
    ci = locate_cell(px, w);
    cj = locate_cell(py, w);
    if (ci >= 0 && ci < eff_width() && cj >= 0 && cj < eff_height()) begin
      ia = int'(ci) * GRID_H + int'(cj);
      ib = int'(ci) * (GRID_H + 1) + int'(cj);
      for (int k = 0; k < 2; k++) begin
        if (!u_set[ia + k * GRID_H])
          queue_write(OP_WR_U, int'(ci) + k, int'(cj), pick_value());
        if (!us_set[ia + k * GRID_H])
          queue_write(OP_WR_SAVED_U, int'(ci) + k, int'(cj), pick_value());
        if (!v_set[ib + k]) queue_write(OP_WR_V, int'(ci), int'(cj) + k, pick_value());
        if (!vs_set[ib + k])
          queue_write(OP_WR_SAVED_V, int'(ci), int'(cj) + k, pick_value());
      end
    end
    it = '{op: OP_PARTICLE, col: 7'($urandom), row: 7'($urandom), gval: $urandom,
           px: px, py: py, vx: vx, vy: vy};
    queue_item(it);
  endtask

  // Position along one axis: mostly inside the grid, some at its edges, some anywhere
  function automatic logic [31:0] pick_position(input int ncells);
    longint d, c, p;
    int n;
    d = (cfg_cs == 0) ? 1 : longint'(cfg_cs);
    n = (ncells == 0) ? 1 : ncells;
    case ($urandom_range(0, 9))
      7: c = ($urandom_range(0, 1) != 0) ? -1 : n;
      8, 9: return $urandom;
      default: c = $urandom_range(0, n - 1);
    endcase
    p = c * d + (longint'($urandom) % d);
    if (p > 64'sd2147483647 || p < -64'sd2147483648) return $urandom;
    return p[31:0];
  endfunction

  // Queue random traffic until count items, grid preloads included, are pending
  task automatic queue_random(input int count);
    int sel;
    int start;
    start = items_queued;
    while (items_queued - start < count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
        queue_particle(pick_position(eff_width()), pick_position(eff_height()),
                       pick_value(), pick_value());
      end else if (sel < 90) begin
        case ($urandom_range(0, 3))
          0: queue_write(OP_WR_U, $urandom_range(0, GRID_W), $urandom_range(0, GRID_H - 1),
                         pick_value());
          1: queue_write(OP_WR_V, $urandom_range(0, GRID_W - 1), $urandom_range(0, GRID_H),
                         pick_value());
          2: queue_write(OP_WR_SAVED_U, $urandom_range(0, GRID_W),
                         $urandom_range(0, GRID_H - 1), pick_value());
          default: queue_write(OP_WR_SAVED_V, $urandom_range(0, GRID_W - 1),
                               $urandom_range(0, GRID_H), pick_value());
        endcase
      end else if (sel < 95) begin
        // writes anywhere in the index space, most of them dropped
        queue_write(3'($urandom_range(OP_WR_U, OP_WR_SAVED_V)), $urandom_range(0, 127),
                    $urandom_range(0, 127), $urandom);
      end else begin
        queue_write(3'($urandom_range(OP_UNUSED_MIN, OP_UNUSED_MAX)),
                    $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
      end
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_GRID_WIDTH:  cfg_gw = data[6:0];
      CFG_GRID_HEIGHT: cfg_gh = data[6:0];
      CFG_CELL_SIZE:   cfg_cs = data[30:0];
      CFG_INV_CELL:    cfg_inv = data[30:0];
      CFG_PIC_WEIGHT:  cfg_alpha = data[16:0];
      CFG_UNKNOWN_VEL: cfg_unknown = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input int gw, input int gh, input logic [31:0] cs,
                             input logic [31:0] inv, input logic [31:0] alpha,
                             input logic [31:0] unk);
    write_reg(CFG_GRID_WIDTH, gw);
    write_reg(CFG_GRID_HEIGHT, gh);
    write_reg(CFG_CELL_SIZE, cs);
    write_reg(CFG_INV_CELL, inv);
    write_reg(CFG_PIC_WEIGHT, alpha);
    write_reg(CFG_UNKNOWN_VEL, unk);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every item is in and every velocity is out, then let the pipe drain
  task automatic drain_block();
    while (item_backlog.size() != 0 || in_valid_i || velocity_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    phases_run++;
  endtask

  // Driver: bursts of transfers separated by random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) item_backlog.pop_front();
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (item_backlog.size() != 0) begin
          opcode_i     <= item_backlog[0].op;
          col_i        <= item_backlog[0].col;
          row_i        <= item_backlog[0].row;
          grid_value_i <= item_backlog[0].gval;
          pos_x_i      <= item_backlog[0].px;
          pos_y_i      <= item_backlog[0].py;
          vel_x_i      <= item_backlog[0].vx;
          vel_y_i      <= item_backlog[0].vy;
          in_valid_i   <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer and pattern the ready line
  always @(posedge clk_i) begin
    velocity_t exp_v;
    if (rst_ni) begin
      cyc++;
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (velocity_due.size() == 0) begin
          $display("%0t: unexpected result vx=%h vy=%h inside=%b", $time,
                   new_vel_x_o, new_vel_y_o, inside_grid_o);
          errors++;
        end else begin
          exp_v = velocity_due.pop_front();
          if (new_vel_x_o !== exp_v.vx) begin
            $display("%0t: new_vel_x expected %h actual %h", $time, exp_v.vx, new_vel_x_o);
            errors++;
          end
          if (new_vel_y_o !== exp_v.vy) begin
            $display("%0t: new_vel_y expected %h actual %h", $time, exp_v.vy, new_vel_y_o);
            errors++;
          end
          if (inside_grid_o !== exp_v.in_grid) begin
            $display("%0t: inside_grid expected %b actual %b", $time, exp_v.in_grid,
                     inside_grid_o);
            errors++;
          end
        end
        // long hold-off so the pipeline backs up into the input
        if (results_seen == 120 || results_seen == 450) stall_left = 400;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case ((cyc / 300) % 4)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 9) < 7);
          2: out_ready_i <= (cyc % 5 != 0);
          default: out_ready_i <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] cs;
    cfg_gw = 7'd64;
    cfg_gh = 7'd64;
    cfg_cs = 31'd65536;
    cfg_inv = 31'd65536;
    cfg_alpha = 17'd65536;
    cfg_unknown = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: corner entries, dropped writes, unused opcodes, grid edges
    queue_write(OP_WR_U, GRID_W, GRID_H - 1, 32'h7FFF_FFFF);
    queue_write(OP_WR_V, GRID_W - 1, GRID_H, 32'h8000_0000);
    queue_write(OP_WR_SAVED_U, 0, 0, 32'h8000_0000);
    queue_write(OP_WR_SAVED_V, 0, 0, 32'h7FFF_FFFF);
    queue_write(OP_WR_U, GRID_W + 1, 0, 32'h1234_5678);
    queue_write(OP_WR_U, 0, GRID_H, 32'h1234_5678);
    queue_write(OP_WR_V, GRID_W, 0, 32'h1234_5678);
    queue_write(OP_WR_SAVED_V, 127, 127, 32'hFFFF_FFFF);
    queue_write(OP_UNUSED_MIN, 1, 1, 32'hDEAD_BEEF);
    queue_write(OP_UNUSED_MID, 2, 2, 32'h0);
    queue_write(OP_UNUSED_MAX, 127, 127, 32'hFFFF_FFFF);
    queue_particle(32'h0, 32'h0, 32'h0, 32'h0);
    queue_particle(32'h003F_FFFF, 32'h003F_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_particle(32'h003F_8000, 32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000);
    queue_particle(32'hFFFF_FFFF, 32'h0001_0000, 32'h0, 32'h0);
    queue_particle(32'h0040_0000, 32'h0000_0000, 32'h0, 32'h0);
    queue_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    queue_particle(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    queue_particle(32'h0000_FFFF, 32'h003F_0000, 32'h0, 32'h0);
    drain_block();

    // Fixed settings covering every register and its extremes
    load_config(64, 64, 32'h0001_0000, 32'h0001_0000, 32'd32768, 32'h0030_3900);
    queue_random(130);
    drain_block();
    load_config(1, 1, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'h8000_0000);
    queue_random(130);
    drain_block();
    load_config(127, 100, 32'd0, 32'h7FFF_FFFF, 32'd131071, 32'h7FFF_FFFF);
    queue_random(130);
    drain_block();
    load_config(0, 5, 32'h0003_0000, 32'd21845, 32'd65536, 32'hFFFF_FFFB);
    queue_random(90);
    drain_block();
    load_config(8, 3, 32'h0000_4000, 32'h0004_0000, 32'd40000, $urandom);
    queue_random(130);
    drain_block();

    // Random settings with a roughly matching reciprocal
    for (int p = 0; p < 3; p++) begin
      cs = $urandom_range(32'h0000_1000, 32'h0010_0000);
      load_config($urandom_range(1, 64), $urandom_range(1, 64), cs,
                  32'((64'h1_0000_0000 / cs) + $urandom_range(0, 2)),
                  $urandom_range(0, 65536), $urandom);
      queue_random(130);
      drain_block();
    end

    $display("Covered %0d particles (%0d inside the grid) and %0d grid writes",
             particles_sent, inside_sent, writes_sent);
    $display("over %0d settings, %0d results checked", phases_run, results_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ pic_flip_particle_velocity_top.f @@
rtl/pfpv_pkg.sv
rtl/pfpv_ram.sv
rtl/pfpv_div.sv
rtl/pic_flip_particle_velocity_top.sv
test/pic_flip_particle_velocity_top_tb.sv
